### design/npr_pkg.sv
// shared constants, codes and controller/datapath interface types
package npr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTS_W      = $clog2(MAX_POINTS);
  localparam int N_W        = $clog2(MAX_POINTS + 1);
  localparam int CFG_W      = 7;
  localparam int COORD_W    = 16;
  localparam int WGT_W      = 16;
  localparam int RES_W      = 17;
  localparam int WRES_W     = 25;
  localparam int CNT_W      = 20;
  localparam int TOT_W      = 36;
  localparam int SQ_W       = 34;
  localparam int STEP_W     = 7;

  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 17;
  localparam int MUL_STEPS  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_HIT  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } npr_func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } npr_status_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_LOAD,
    RES_RANGE,
    RES_EMPTY,
    RES_READ,
    RES_HIT
  } npr_kind_t;

  typedef enum logic [1:0] {
    MUL_MEAN = 2'd0,
    MUL_WLO  = 2'd1,
    MUL_WHI  = 2'd2,
    MUL_RW   = 2'd3
  } npr_mul_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TOT_W-1:0] total;
    logic [RES_W-1:0] mean;
    logic [RES_W-1:0] wmean;
  } npr_stats_t;

  typedef struct packed {
    logic             pt_wr;
    logic             pt_rd_en;
    logic [PTS_W-1:0] pt_rd_addr;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             st_rd;
    logic             sel_best;
    logic             mul_en;
    npr_mul_t         mul_sel;
    logic             div_init;
    logic             div_step;
    logic             st_wr;
    logic             res_load;
    npr_kind_t        kind;
  } npr_cmd_t;

  typedef struct packed {
    npr_func_t      func;
    logic [N_W-1:0] n_act;
    logic           idx_lt_n;
    logic           idx_lt_max;
    logic           scan_busy;
  } npr_sts_t;

endpackage

### design/npr_dp.sv
// datapath: point and statistics memories, distance scan, square root, multiply, divide
module npr_dp import npr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_take,
  input  logic [1:0]                func,
  input  logic [PTS_W-1:0]          point_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [WGT_W-1:0]          hit_weight,
  input  npr_cmd_t                  cmd,
  output npr_sts_t                  sts,
  output logic [1:0]                status,
  output logic [PTS_W-1:0]          nearest_index,
  output logic [RES_W-1:0]          residual,
  output logic [WRES_W-1:0]         weighted_residual,
  output logic [RES_W-1:0]          mean_residual,
  output logic [RES_W-1:0]          weighted_mean_residual,
  output logic [CNT_W-1:0]          hit_count,
  output logic [TOT_W-1:0]          weight_total
);

  logic [CFG_W-1:0]          piu;
  logic [N_W-1:0]            n_act;
  npr_func_t                 func_q;
  logic [PTS_W-1:0]          idx_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [WGT_W-1:0]          wt_q;

  // point memory and scan pipeline
  logic [3*COORD_W-1:0] pt_mem [MAX_POINTS];
  logic [3*COORD_W-1:0] pt_q;
  logic                 v0, v1, v2;
  logic [PTS_W-1:0]     t0, t1, t2;
  logic [COORD_W-1:0]   ad0, ad1, ad2;
  logic [2*COORD_W-1:0] sq0, sq1, sq2;
  logic [COORD_W:0]     df0, df1, df2;
  logic [SQ_W-1:0]      sum, best_sq;
  logic [PTS_W-1:0]     best_idx;

  // square root
  logic [SQ_W-1:0]  sr_src;
  logic [RES_W+1:0] sr_rem;
  logic [RES_W-1:0] root;
  logic [RES_W+3:0] sr_rem2, sr_trial;

  // statistics memory
  npr_stats_t            st_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] st_vld;
  npr_stats_t            st_q, st_new;
  logic [PTS_W-1:0]      st_addr;

  // multiply and divide
  logic [CNT_W-1:0]     mul_a;
  logic [RES_W-1:0]     mul_b;
  logic [CNT_W+RES_W-1:0] prod;
  logic [CNT_W+RES_W:0] acc_m;
  logic [TOT_W+RES_W:0] acc_w;
  logic [RES_W+WGT_W-1:0] rw_q;
  logic [CNT_W:0]       dm, rm;
  logic [CNT_W+1:0]     tm;
  logic [TOT_W:0]       dw, rw;
  logic [TOT_W+1:0]     tw;
  logic [RES_W-1:0]     nm, nw, qm, qw;

  assign n_act = (piu > CFG_W'(MAX_POINTS)) ? N_W'(MAX_POINTS) : N_W'(piu);

  always_comb begin
    sts.func       = func_q;
    sts.n_act      = n_act;
    sts.idx_lt_n   = N_W'(idx_q) < n_act;
    sts.idx_lt_max = N_W'(idx_q) < N_W'(MAX_POINTS);
    sts.scan_busy  = v0 | v1 | v2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      piu <= '0;
    end else if (cfg_we) begin
      piu <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_q <= npr_func_t'(func);
      idx_q  <= point_index;
      cx_q   <= coord_x;
      cy_q   <= coord_y;
      cz_q   <= coord_z;
      wt_q   <= hit_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_wr) begin
      pt_mem[idx_q] <= {cz_q, cy_q, cx_q};
    end
    if (cmd.pt_rd_en) begin
      pt_q <= pt_mem[cmd.pt_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.pt_rd_en;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_comb begin
    df0 = {cx_q[COORD_W-1], cx_q} - {pt_q[COORD_W-1], pt_q[COORD_W-1:0]};
    df1 = {cy_q[COORD_W-1], cy_q} - {pt_q[2*COORD_W-1], pt_q[2*COORD_W-1:COORD_W]};
    df2 = {cz_q[COORD_W-1], cz_q} - {pt_q[3*COORD_W-1], pt_q[3*COORD_W-1:2*COORD_W]};
    sum = SQ_W'(sq0) + SQ_W'(sq1) + SQ_W'(sq2);
  end

  always_ff @(posedge clk) begin
    t0  <= cmd.pt_rd_addr;
    t1  <= t0;
    t2  <= t1;
    ad0 <= df0[COORD_W] ? COORD_W'(-df0) : df0[COORD_W-1:0];
    ad1 <= df1[COORD_W] ? COORD_W'(-df1) : df1[COORD_W-1:0];
    ad2 <= df2[COORD_W] ? COORD_W'(-df2) : df2[COORD_W-1:0];
    sq0 <= ad0 * ad0;
    sq1 <= ad1 * ad1;
    sq2 <= ad2 * ad2;
    if (v2 && (t2 == '0 || sum < best_sq)) begin
      best_sq  <= sum;
      best_idx <= t2;
    end
  end

  // one root bit per step
  always_comb begin
    sr_rem2  = {sr_rem, sr_src[SQ_W-1 -: 2]};
    sr_trial = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sr_src <= best_sq;
      sr_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sr_src <= sr_src << 2;
      if (sr_rem2 >= sr_trial) begin
        sr_rem <= (RES_W+2)'(sr_rem2 - sr_trial);
        root   <= {root[RES_W-2:0], 1'b1};
      end else begin
        sr_rem <= sr_rem2[RES_W+1:0];
        root   <= {root[RES_W-2:0], 1'b0};
      end
    end
  end

  assign st_addr = cmd.sel_best ? best_idx : idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (cmd.pt_wr) begin
      st_vld[idx_q] <= 1'b1;
    end else if (cmd.st_wr) begin
      st_vld[best_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_wr) begin
      st_mem[idx_q] <= '0;
    end else if (cmd.st_wr) begin
      st_mem[best_idx] <= st_new;
    end
    if (cmd.st_rd) begin
      st_q <= st_vld[st_addr] ? st_mem[st_addr] : '0;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_MEAN: begin
        mul_a = st_q.count;
        mul_b = st_q.mean;
      end
      MUL_WLO: begin
        mul_a = CNT_W'(st_q.total[TOT_W/2-1:0]);
        mul_b = st_q.wmean;
      end
      MUL_WHI: begin
        mul_a = CNT_W'(st_q.total[TOT_W-1:TOT_W/2]);
        mul_b = st_q.wmean;
      end
      default: begin
        mul_a = CNT_W'(wt_q);
        mul_b = root;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_MEAN: acc_m <= (CNT_W+RES_W+1)'(prod) + (CNT_W+RES_W+1)'(root);
        MUL_WLO:  acc_w <= (TOT_W+RES_W+1)'(prod);
        MUL_WHI:  acc_w <= acc_w + ((TOT_W+RES_W+1)'(prod) << (TOT_W/2));
        default: begin
          acc_w <= acc_w + (TOT_W+RES_W+1)'(prod);
          rw_q  <= prod[RES_W+WGT_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    dm = {1'b0, st_q.count} + (CNT_W+1)'(1);
    dw = {1'b0, st_q.total} + (TOT_W+1)'(wt_q);
    tm = {rm, nm[RES_W-1]};
    tw = {rw, nw[RES_W-1]};
  end

  // two restoring dividers in lockstep, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rm <= acc_m[CNT_W+RES_W:RES_W];
      nm <= acc_m[RES_W-1:0];
      rw <= acc_w[TOT_W+RES_W:RES_W];
      nw <= acc_w[RES_W-1:0];
      qm <= '0;
      qw <= '0;
    end else if (cmd.div_step) begin
      nm <= nm << 1;
      nw <= nw << 1;
      if (tm >= {1'b0, dm}) begin
        rm <= (CNT_W+1)'(tm - {1'b0, dm});
        qm <= {qm[RES_W-2:0], 1'b1};
      end else begin
        rm <= tm[CNT_W:0];
        qm <= {qm[RES_W-2:0], 1'b0};
      end
      if (tw >= {1'b0, dw}) begin
        rw <= (TOT_W+1)'(tw - {1'b0, dw});
        qw <= {qw[RES_W-2:0], 1'b1};
      end else begin
        rw <= tw[TOT_W:0];
        qw <= {qw[RES_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    st_new.count = (st_q.count == CNT_MAX) ? CNT_MAX : st_q.count + CNT_W'(1);
    st_new.total = (dw > {1'b0, TOT_MAX}) ? TOT_MAX : dw[TOT_W-1:0];
    st_new.mean  = qm;
    st_new.wmean = (dw == '0) ? st_q.wmean : qw;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status                 <= ST_OK;
      nearest_index          <= '0;
      residual               <= '0;
      weighted_residual      <= '0;
      mean_residual          <= '0;
      weighted_mean_residual <= '0;
      hit_count              <= '0;
      weight_total           <= '0;
      case (cmd.kind)
        RES_LOAD: nearest_index <= idx_q;
        RES_RANGE: status <= ST_RANGE;
        RES_EMPTY: status <= ST_EMPTY;
        RES_READ: begin
          nearest_index          <= idx_q;
          mean_residual          <= st_q.mean;
          weighted_mean_residual <= st_q.wmean;
          hit_count              <= st_q.count;
          weight_total           <= st_q.total;
        end
        RES_HIT: begin
          nearest_index          <= best_idx;
          residual               <= root;
          weighted_residual      <= rw_q[RES_W+WGT_W-1:8];
          mean_residual          <= st_new.mean;
          weighted_mean_residual <= st_new.wmean;
          hit_count              <= st_new.count;
          weight_total           <= st_new.total;
        end
        default: status <= ST_OK;
      endcase
    end
  end

endmodule

### design/npr_ctrl.sv
// controller: sequences load, hit and read items through the datapath
module npr_ctrl import npr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  npr_sts_t sts,
  output npr_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DRAIN, S_SQRT, S_STRD, S_MUL, S_DIV, S_WRITE, S_RESP
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] cnt;
  npr_kind_t         kind_q;
  logic              slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.kind       = kind_q;
    cmd.pt_rd_addr = cnt[PTS_W-1:0];
    cmd.mul_sel    = npr_mul_t'(cnt[1:0]);
    case (state)
      S_DECODE: begin
        cmd.pt_wr = (sts.func == FUNC_LOAD) && sts.idx_lt_max;
        cmd.st_rd = (sts.func == FUNC_READ) && sts.idx_lt_n;
      end
      S_SCAN: cmd.pt_rd_en = 1'b1;
      S_SQRT: begin
        cmd.sqrt_init = (cnt == '0);
        cmd.sqrt_step = (cnt != '0);
      end
      S_STRD: begin
        cmd.st_rd    = 1'b1;
        cmd.sel_best = 1'b1;
      end
      S_MUL: cmd.mul_en = 1'b1;
      S_DIV: begin
        cmd.div_init = (cnt == '0);
        cmd.div_step = (cnt != '0);
      end
      S_WRITE: begin
        cmd.st_wr    = 1'b1;
        cmd.sel_best = 1'b1;
      end
      S_RESP: cmd.res_load = slot_free;
      default: cmd.res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      kind_q    <= RES_ZERO;
      out_valid <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt   <= '0;
          state <= S_RESP;
          case (sts.func)
            FUNC_LOAD: kind_q <= sts.idx_lt_max ? RES_LOAD : RES_RANGE;
            FUNC_HIT: begin
              if (sts.n_act == '0) begin
                kind_q <= RES_EMPTY;
              end else begin
                state <= S_SCAN;
              end
            end
            FUNC_READ: kind_q <= sts.idx_lt_n ? RES_READ : RES_RANGE;
            default: kind_q <= RES_ZERO;
          endcase
        end
        S_SCAN: begin
          if (cnt + STEP_W'(1) == STEP_W'(sts.n_act)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_DRAIN: begin
          cnt <= '0;
          if (!sts.scan_busy) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt == STEP_W'(SQRT_STEPS)) begin
            state <= S_STRD;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_STRD: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (cnt == STEP_W'(MUL_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_DIV: begin
          if (cnt == STEP_W'(DIV_STEPS)) begin
            state <= S_WRITE;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_WRITE: begin
          kind_q <= RES_HIT;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pt_rd_en |-> (cnt < STEP_W'(sts.n_act)))
    else $error("scan beyond points in use");
  a_take_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not stall the input");
  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result appeared outside respond state");
`endif

endmodule

### design/nearest_point_residual_tracker_unit.sv
// top level of the nearest point residual tracker
// One item at a time. A load, read or unknown item is decoded and its result
// loaded. A hit runs through a decode step, a distance scan of one stored
// point per cycle through the single read port of the point memory, a
// pipeline drain, a bit-serial square root, a statistics read, 4 steps of
// the shared 20x17 multiplier, the two lockstep restoring dividers, a write
// back and the result load. A new item is accepted as soon as the previous
// result is loaded into the output register, even if that result is still
// stalled. There is no clearing pass after reset: statistics read as zero
// through per-point valid bits; point coordinates are undefined until loaded.
// The single register points_in_use must be written only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
module nearest_point_residual_tracker_unit import npr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // item input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [PTS_W-1:0]          point_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [WGT_W-1:0]          hit_weight,
  // result output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [PTS_W-1:0]          nearest_index,
  output logic [RES_W-1:0]          residual,
  output logic [WRES_W-1:0]         weighted_residual,
  output logic [RES_W-1:0]          mean_residual,
  output logic [RES_W-1:0]          weighted_mean_residual,
  output logic [CNT_W-1:0]          hit_count,
  output logic [TOT_W-1:0]          weight_total,
  // points_in_use register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data
);

  npr_cmd_t cmd;
  npr_sts_t sts;
  logic     in_take;

  // register write is always accepted
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;

  // sequencer
  npr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memories and arithmetic
  npr_dp u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_data               (cfg_data),
    .in_take                (in_take),
    .func                   (func),
    .point_index            (point_index),
    .coord_x                (coord_x),
    .coord_y                (coord_y),
    .coord_z                (coord_z),
    .hit_weight             (hit_weight),
    .cmd                    (cmd),
    .sts                    (sts),
    .status                 (status),
    .nearest_index          (nearest_index),
    .residual               (residual),
    .weighted_residual      (weighted_residual),
    .mean_residual          (mean_residual),
    .weighted_mean_residual (weighted_mean_residual),
    .hit_count              (hit_count),
    .weight_total           (weight_total)
  );

endmodule

### tb/sv/testbench.sv
// testbench for the nearest point residual tracker: directed and random items checked against a predictor
module testbench;
  import npr_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [PTS_W-1:0]  nearest_index;
    logic [RES_W-1:0]  residual;
    logic [WRES_W-1:0] weighted_residual;
    logic [RES_W-1:0]  mean_residual;
    logic [RES_W-1:0]  weighted_mean_residual;
    logic [CNT_W-1:0]  hit_count;
    logic [TOT_W-1:0]  weight_total;
  } tracker_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                func = 2'd0;
  logic [PTS_W-1:0]          point_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic [WGT_W-1:0]          hit_weight = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic [PTS_W-1:0]          nearest_index;
  logic [RES_W-1:0]          residual;
  logic [WRES_W-1:0]         weighted_residual;
  logic [RES_W-1:0]          mean_residual;
  logic [RES_W-1:0]          weighted_mean_residual;
  logic [CNT_W-1:0]          hit_count;
  logic [TOT_W-1:0]          weight_total;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_data = '0;

  nearest_point_residual_tracker_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .point_index(point_index),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .hit_weight(hit_weight),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .nearest_index(nearest_index), .residual(residual),
    .weighted_residual(weighted_residual), .mean_residual(mean_residual),
    .weighted_mean_residual(weighted_mean_residual), .hit_count(hit_count),
    .weight_total(weight_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock: period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the block state
  logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
  logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
  logic signed [COORD_W-1:0] pt_z [MAX_POINTS];
  bit                        pt_loaded [MAX_POINTS];
  logic [CNT_W-1:0]          hits_n [MAX_POINTS];
  logic [TOT_W-1:0]          wsum [MAX_POINTS];
  logic [RES_W-1:0]          avg_r [MAX_POINTS];
  logic [RES_W-1:0]          wavg_r [MAX_POINTS];
  logic [CFG_W-1:0]          pts_reg = '0;

  tracker_result_t expected_q [$];
  int  mismatches = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;
  int  stall_mode = 0;
  int  stall_run = 0;

  // floor square root, one bit per pass from the top
  function automatic logic [RES_W-1:0] floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned t;
    root = 0;
    for (int b = RES_W - 1; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= v) root = t;
    end
    return root[RES_W-1:0];
  endfunction

  // expected result of one accepted item; updates the predictor state
  function automatic tracker_result_t track_item(npr_func_t f, logic [PTS_W-1:0] idx,
      logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
      logic signed [COORD_W-1:0] z, logic [WGT_W-1:0] w);
    tracker_result_t r;
    int n;
    int best;
    longint unsigned sq, best_sq, dx, dy, dz, rr, nn, ww, w1, mean_q, wmean_q;
    r = '0;
    n = (pts_reg > MAX_POINTS) ? MAX_POINTS : pts_reg;
    case (f)
      FUNC_LOAD: begin
        pt_x[idx] = x; pt_y[idx] = y; pt_z[idx] = z; pt_loaded[idx] = 1'b1;
        hits_n[idx] = '0; wsum[idx] = '0; avg_r[idx] = '0; wavg_r[idx] = '0;
        r.nearest_index = idx;
      end
      FUNC_HIT: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          best_sq = 0;
          for (int j = 0; j < n; j++) begin
            dx = (x > pt_x[j]) ? longint'(x) - longint'(pt_x[j]) : longint'(pt_x[j]) - longint'(x);
            dy = (y > pt_y[j]) ? longint'(y) - longint'(pt_y[j]) : longint'(pt_y[j]) - longint'(y);
            dz = (z > pt_z[j]) ? longint'(z) - longint'(pt_z[j]) : longint'(pt_z[j]) - longint'(z);
            sq = dx * dx + dy * dy + dz * dz;
            // strict less-than keeps the lowest index on a tie
            if (j == 0 || sq < best_sq) begin
              best_sq = sq;
              best = j;
            end
          end
          rr = floor_root(best_sq);
          nn = hits_n[best];
          mean_q = (nn * avg_r[best] + rr) / (nn + 1);
          avg_r[best] = mean_q[RES_W-1:0];
          hits_n[best] = (nn + 1 > CNT_MAX) ? CNT_MAX : nn + 1;
          ww = wsum[best];
          w1 = ww + w;
          // zero weight sum leaves the weighted mean alone
          if (w1 != 0) begin
            wmean_q = (ww * wavg_r[best] + rr * w) / w1;
            wavg_r[best] = wmean_q[RES_W-1:0];
          end
          wsum[best] = (w1 > TOT_MAX) ? TOT_MAX : w1;
          r.nearest_index = best;
          r.residual = rr;
          r.weighted_residual = (rr * w) >> 8;
          r.mean_residual = avg_r[best];
          r.weighted_mean_residual = wavg_r[best];
          r.hit_count = hits_n[best];
          r.weight_total = wsum[best];
        end
      end
      FUNC_READ: begin
        if (idx >= n) begin
          r.status = ST_RANGE;
        end else begin
          r.nearest_index = idx;
          r.mean_residual = avg_r[idx];
          r.weighted_mean_residual = wavg_r[idx];
          r.hit_count = hits_n[idx];
          r.weight_total = wsum[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one item; bursts of random length, with random gaps in between when sender_gaps is set
  task automatic send_item(npr_func_t f, logic [PTS_W-1:0] idx,
      logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
      logic signed [COORD_W-1:0] z, logic [WGT_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      if (sender_gaps) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    func        <= f;
    point_index <= idx;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    hit_weight  <= w;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(track_item(f, idx, x, y, z, w));
    burst_left--;
  endtask

  // hold the input side until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_points_in_use(logic [CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pts_reg = v;
  endtask

  // load every point that a hit would search but that holds no coordinates yet
  task automatic fill_searched_points();
    int n;
    n = (pts_reg > MAX_POINTS) ? MAX_POINTS : pts_reg;
    for (int j = 0; j < n; j++)
      if (!pt_loaded[j])
        send_item(FUNC_LOAD, j, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic test_directed();
    // nothing in use: hit reports empty, read is out of range, unknown func gives zeros
    send_item(FUNC_HIT, 0, 16'sd5, 16'sd5, 16'sd5, 16'h0100);
    send_item(FUNC_READ, 0, '0, '0, '0, '0);
    send_item(FUNC_NONE, 6'h3f, 16'h7fff, 16'h8000, 16'hffff, 16'hffff);
    write_points_in_use(7'd3);
    send_item(FUNC_LOAD, 0, 16'sh8000, 16'sh8000, 16'sh8000, '0);
    send_item(FUNC_LOAD, 1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
    send_item(FUNC_LOAD, 2, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0);
    // hit on the corner where point 0 lies, full weight
    send_item(FUNC_HIT, 6'h3f, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
    send_item(FUNC_HIT, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
    // tie between the two equal points goes to the lower index
    send_item(FUNC_HIT, 0, 16'sh7000, 16'sh7000, 16'sh7000, 16'h0000);
    // zero weight into a point with a nonzero weight sum
    send_item(FUNC_HIT, 0, 16'sh8000, 16'sh8010, 16'sh8000, 16'h0000);
    send_item(FUNC_HIT, 0, 16'sh8000, 16'sh8000, 16'sh8003, 16'h0180);
    send_item(FUNC_READ, 0, '0, '0, '0, '0);
    send_item(FUNC_READ, 1, '0, '0, '0, '0);
    send_item(FUNC_READ, 3, '0, '0, '0, '0);
    send_item(FUNC_READ, 6'h3f, '0, '0, '0, '0);
    // reload clears the statistics
    send_item(FUNC_LOAD, 1, 16'sh0000, 16'sh0000, 16'sh0000, '0);
    send_item(FUNC_READ, 1, '0, '0, '0, '0);
    send_item(FUNC_LOAD, 6'h3f, 16'sh1234, 16'shedcb, 16'sh0001, '0);
    // register above the store size is clamped
    write_points_in_use(7'd127);
    fill_searched_points();
    send_item(FUNC_HIT, 0, 16'sh1234, 16'shedcb, 16'sh0001, 16'h8000);
    send_item(FUNC_READ, 6'h3f, '0, '0, '0, '0);
    write_points_in_use(7'd64);
    send_item(FUNC_HIT, 0, 16'sh1234, 16'shedcb, 16'sh0002, 16'hffff);
    send_item(FUNC_READ, 6'h3f, '0, '0, '0, '0);
  endtask

  task automatic test_random_phase(logic [CFG_W-1:0] setting, int items, bit gaps);
    int n, sel, j;
    logic signed [COORD_W-1:0] x, y, z;
    logic [WGT_W-1:0] w;
    write_points_in_use(setting);
    sender_gaps = gaps;
    fill_searched_points();
    n = (pts_reg > MAX_POINTS) ? MAX_POINTS : pts_reg;
    for (int k = 0; k < items; k++) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: w = '0;
        1: w = 16'hffff;
        default: w = $urandom;
      endcase
      if (k == items / 2) drain_results();
      if (sel < 55) begin
        // hits mostly land near a stored point so statistics build up
        if (n != 0 && $urandom_range(0, 3) != 0) begin
          j = $urandom_range(0, n - 1);
          x = nudge(pt_x[j], 40); y = nudge(pt_y[j], 40); z = nudge(pt_z[j], 40);
        end else begin
          x = $urandom; y = $urandom; z = $urandom;
        end
        send_item(FUNC_HIT, $urandom, x, y, z, w);
      end else if (sel < 70) begin
        // some loads copy another point to make distance ties
        j = $urandom_range(0, MAX_POINTS - 1);
        if (n != 0 && $urandom_range(0, 2) == 0) begin
          sel = $urandom_range(0, n - 1);
          send_item(FUNC_LOAD, j, pt_x[sel], pt_y[sel], pt_z[sel], w);
        end else begin
          send_item(FUNC_LOAD, j, $urandom, $urandom, $urandom, w);
        end
      end else if (sel < 95) begin
        send_item(FUNC_READ, $urandom, $urandom, $urandom, $urandom, w);
      end else begin
        send_item(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, w);
      end
    end
  endtask

  // receiver stall pattern: off, random, or long runs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run == 0) begin
            stall_run = $urandom_range(1, 20);
            out_stall <= ~out_stall;
          end else begin
            stall_run--;
          end
        end
      endcase
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    tracker_result_t act, exp_r;
    if (!rst && out_valid && !out_stall) begin
      act = {status, nearest_index, residual, weighted_residual, mean_residual,
             weighted_mean_residual, hit_count, weight_total};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", act);
      end else begin
        exp_r = expected_q.pop_front();
        if (act !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch");
            $display("  expected: %p", exp_r);
            $display("  actual:   %p", act);
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      pt_x[i] = '0; pt_y[i] = '0; pt_z[i] = '0; pt_loaded[i] = 1'b0;
      hits_n[i] = '0; wsum[i] = '0; avg_r[i] = '0; wavg_r[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    stall_mode = 1;
    test_directed();
    stall_mode = 0;
    test_random_phase(7'd1, 250, 1'b0);
    stall_mode = 1;
    test_random_phase(7'd64, 400, 1'b1);
    stall_mode = 2;
    test_random_phase($urandom_range(2, 63), 400, 1'b1);
    stall_mode = 1;
    test_random_phase(7'd0, 150, 1'b1);
    stall_mode = 2;
    test_random_phase(7'd100, 350, 1'b0);
    stall_mode = 1;
    test_random_phase($urandom_range(1, 64), 450, 1'b1);
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("nearest_point_residual_tracker_unit: match");
    else
      $display("nearest_point_residual_tracker_unit: mismatch");
    $finish;
  end

  // run limit well past the slowest correct run
  initial begin
    #(4 * 4000000);
    $display("nearest_point_residual_tracker_unit: mismatch");
    $finish;
  end

endmodule

### files.f
design/npr_pkg.sv
design/npr_dp.sv
design/npr_ctrl.sv
design/nearest_point_residual_tracker_unit.sv
tb/sv/testbench.sv
